@@ hdl/framebuffer_alpha_blend_pixel_port_unit_assert.svh @@
// assertion macros for the pixel port unit
`ifndef FRAMEBUFFER_ALPHA_BLEND_PIXEL_PORT_UNIT_ASSERT_SVH
`define FRAMEBUFFER_ALPHA_BLEND_PIXEL_PORT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define FBAB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define FBAB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FBAB_ASSERT_SAME(lbl, ante, cons, msg)
`define FBAB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hdl/fbab_pkg.sv @@
`timescale 1ns / 1ps
package fbab_pkg;

	localparam int unsigned WIDTH     = 320;
	localparam int unsigned HEIGHT    = 240;
	localparam int unsigned NPIX      = WIDTH * HEIGHT;
	localparam int unsigned ADDR_W    = $clog2(NPIX);
	localparam int unsigned COORD_W   = 12;
	localparam int unsigned XY_W      = COORD_W - 1;
	localparam int unsigned COLOR_W   = 32;
	localparam int unsigned OP_W      = 2;
	localparam int unsigned IN_DATA_W = 2 * COORD_W + COLOR_W;

	typedef logic [OP_W-1:0] opcode_t;

	localparam opcode_t OP_WRITE = 2'd0;
	localparam opcode_t OP_READ  = 2'd1;
	localparam opcode_t OP_FILL  = 2'd2;

	typedef enum logic [1:0] {
		WSEL_ONES,
		WSEL_FILL,
		WSEL_COLOR,
		WSEL_BLEND
	} wsel_t;

	typedef struct packed {
		logic  load_in;
		logic  mem_we;
		wsel_t wsel;
		logic  sweep_en;
		logic  load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		opcode_t opcode;
		logic    in_bounds;
		logic    sweep_last;
	} dp_stat_t;

endpackage

@@ hdl/fbab_ctrl.sv @@
`timescale 1ns / 1ps
module fbab_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 cfg_valid,
	input  logic                 cfg_data,
	input  fbab_pkg::dp_stat_t   stat,
	output fbab_pkg::ctrl_cmd_t  cmd
);
	import fbab_pkg::*;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_MULT,
		ST_MIX,
		ST_FILL,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   alpha_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.wsel     = WSEL_COLOR;
		unique case (state_q)
			ST_INIT: begin
				cmd.mem_we   = 1'b1;
				cmd.wsel     = WSEL_ONES;
				cmd.sweep_en = 1'b1;
			end
			ST_IDLE: begin
				cmd.load_in = in_valid;
			end
			ST_DECODE: begin
				cmd.mem_we = (stat.opcode == OP_WRITE) && stat.in_bounds && !alpha_q;
			end
			ST_MULT: begin
				cmd.mem_we = 1'b0;
			end
			ST_MIX: begin
				cmd.mem_we = 1'b1;
				cmd.wsel   = WSEL_BLEND;
			end
			ST_FILL: begin
				cmd.mem_we   = 1'b1;
				cmd.wsel     = WSEL_FILL;
				cmd.sweep_en = 1'b1;
			end
			ST_RESULT: begin
				cmd.load_out = !out_valid_q || out_ready;
			end
			default: begin
				cmd.mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
			alpha_q     <= 1'b1;
		end else begin
			if (cfg_valid) begin
				alpha_q <= cfg_data;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					if (stat.sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					case (stat.opcode)
						OP_WRITE: state_q <= (stat.in_bounds && alpha_q) ? ST_MULT : ST_RESULT;
						OP_FILL:  state_q <= ST_FILL;
						default:  state_q <= ST_RESULT;
					endcase
				end
				ST_MULT: begin
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					state_q <= ST_RESULT;
				end
				ST_FILL: begin
					if (stat.sweep_last) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

endmodule

@@ hdl/fbab_datapath.sv @@
`timescale 1ns / 1ps
module fbab_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [fbab_pkg::IN_DATA_W-1:0]    in_data,
	input  fbab_pkg::opcode_t                 in_opcode,
	input  fbab_pkg::ctrl_cmd_t               cmd,
	output fbab_pkg::dp_stat_t                stat,
	output logic [fbab_pkg::COLOR_W-1:0]      out_data,
	output logic                              out_flag
);
	import fbab_pkg::*;

	function automatic logic [7:0] div255(input logic [15:0] p);
		logic [16:0] t;
		t = 17'(p) + 17'd1 + 17'(p[15:8]);
		return t[15:8];
	endfunction

	opcode_t                    opcode_q;
	logic signed [COORD_W-1:0]  pos_x_q;
	logic signed [COORD_W-1:0]  pos_y_q;
	logic [COLOR_W-1:0]         color_q;
	logic [ADDR_W-1:0]          fill_idx_q;
	logic [COLOR_W-1:0]         mem_q [NPIX];
	logic [COLOR_W-1:0]         rd_q;
	logic [15:0]                src_prod_s1 [3];
	logic [15:0]                bk_prod_s1 [3];
	logic [COLOR_W-1:0]         out_data_q;
	logic                       out_flag_q;

	logic [2*XY_W-1:0]          addr_wide;
	logic [ADDR_W-1:0]          addr_c;
	logic                       inside_c;
	logic [ADDR_W-1:0]          waddr_c;
	logic [COLOR_W-1:0]         wdata_c;
	logic [COLOR_W-1:0]         blend_c;

	assign inside_c = !pos_x_q[COORD_W-1] && ({1'b0, pos_x_q[XY_W-1:0]} < COORD_W'(WIDTH))
		&& !pos_y_q[COORD_W-1] && ({1'b0, pos_y_q[XY_W-1:0]} < COORD_W'(HEIGHT));
	assign addr_wide = (2*XY_W)'(pos_y_q[XY_W-1:0]) * (2*XY_W)'(WIDTH)
		+ (2*XY_W)'(pos_x_q[XY_W-1:0]);
	assign addr_c = addr_wide[ADDR_W-1:0];

	assign stat.opcode     = opcode_q;
	assign stat.in_bounds  = inside_c;
	assign stat.sweep_last = (fill_idx_q == ADDR_W'(NPIX - 1));

	// source-over mix of r, g, b; alpha byte comes out zero
	always_comb begin
		blend_c = '0;
		for (int c = 0; c < 3; c++) begin
			blend_c[8*c +: 8] = div255(src_prod_s1[c]) + rd_q[8*c +: 8]
				- div255(bk_prod_s1[c]);
		end
	end

	always_comb begin
		waddr_c = addr_c;
		wdata_c = color_q;
		case (cmd.wsel)
			WSEL_ONES: begin
				waddr_c = fill_idx_q;
				wdata_c = '1;
			end
			WSEL_FILL: begin
				waddr_c = fill_idx_q;
				wdata_c = color_q;
			end
			WSEL_BLEND: begin
				wdata_c = blend_c;
			end
			default: begin
				wdata_c = color_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_idx_q <= '0;
		end else if (cmd.sweep_en) begin
			fill_idx_q <= stat.sweep_last ? '0 : fill_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem_q[waddr_c] <= wdata_c;
		end
		rd_q <= mem_q[addr_c];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			opcode_q <= in_opcode;
			pos_x_q  <= in_data[COORD_W-1:0];
			pos_y_q  <= in_data[2*COORD_W-1:COORD_W];
			color_q  <= in_data[IN_DATA_W-1:2*COORD_W];
		end
		for (int c = 0; c < 3; c++) begin
			src_prod_s1[c] <= 16'(color_q[8*c +: 8]) * 16'(color_q[31:24]);
			bk_prod_s1[c]  <= 16'(rd_q[8*c +: 8]) * 16'(color_q[31:24]);
		end
		if (cmd.load_out) begin
			out_data_q <= ((opcode_q == OP_READ) && inside_c) ? rd_q : '0;
			out_flag_q <= ((opcode_q == OP_READ) || (opcode_q == OP_WRITE)) && inside_c;
		end
	end

	assign out_data = out_data_q;
	assign out_flag = out_flag_q;

endmodule

@@ hdl/framebuffer_alpha_blend_pixel_port_unit.sv @@
`timescale 1ns / 1ps
// pixel port of a 320 by 240 store of 32-bit rgba colors
// s_axis: one command word per item; tuser holds the opcode (write, read, fill),
//   tdata holds pos_x, pos_y, color
// m_axis: one result word per item; tdata is the pixel read (zero unless an
//   on-screen read), tuser is the on-screen flag
// cfg: one-bit alpha enable, always ready; write it only while the unit is idle
// plain write, off-screen write and read: the decode step, then the result step
// blended write: the store read, the multiply stage and the mix before the result step
// fill: a sweep over all 76800 store words, one store word written per cycle
// one item is in flight at a time; the next is taken once the result sits in
// the output register, so a stalled receiver holds back at most one word
// after reset all 76800 store words are swept to all ones, during which
// no command is accepted; alpha enable resets to 1
// a stalled receiver keeps the result word and stops the unit in its result step
module framebuffer_alpha_blend_pixel_port_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [fbab_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // pos_x, pos_y, color
	input  logic [fbab_pkg::OP_W-1:0]        s_axis_tuser,  // opcode
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [fbab_pkg::COLOR_W-1:0]     m_axis_tdata,  // read_color
	output logic                             m_axis_tuser,  // on_screen
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_data
);
	import fbab_pkg::*;

	`include "framebuffer_alpha_blend_pixel_port_unit_assert.svh"

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	assign cfg_ready = 1'b1;

	fbab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.cmd       (cmd)
	);

	fbab_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.in_opcode (s_axis_tuser),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_axis_tdata),
		.out_flag  (m_axis_tuser)
	);

	`FBAB_ASSERT_SAME(a_no_accept_in_sweep, cmd.sweep_en, !s_axis_tready, "word accepted during sweep")
	`FBAB_ASSERT_SAME(a_no_result_overwrite, cmd.load_out, !m_axis_tvalid || m_axis_tready, "result overwritten")
	`FBAB_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken")
	`FBAB_ASSERT_SAME(a_write_on_screen, cmd.mem_we && (cmd.wsel == WSEL_COLOR || cmd.wsel == WSEL_BLEND), stat.in_bounds, "off-screen pixel write")

endmodule

@@ test/tb_framebuffer_alpha_blend_pixel_port_unit.sv @@
`timescale 1ns / 1ps
module tb_framebuffer_alpha_blend_pixel_port_unit;
	import fbab_pkg::*;

	localparam opcode_t     OP_NONE     = 2'd3;
	localparam int unsigned STALL_LIMIT = 250000;
	localparam int unsigned RAND_PHASES = 4;
	localparam int unsigned PHASE_ITEMS = 400;
	localparam int unsigned SETTLE      = 8;

	typedef struct {
		opcode_t              op;
		logic [COORD_W-1:0]   px;
		logic [COORD_W-1:0]   py;
		logic [COLOR_W-1:0]   color;
	} pix_cmd_t;

	typedef struct {
		logic [COLOR_W-1:0]   rd_color;
		logic                 on_scr;
	} pix_res_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;  // pos_x, pos_y, color
	logic [OP_W-1:0]        s_axis_tuser  = '0;  // opcode
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [COLOR_W-1:0]     m_axis_tdata;        // read_color
	logic                   m_axis_tuser;        // on_screen
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic                   cfg_data      = 1'b0;

	logic [COLOR_W-1:0] pix_mem [0:NPIX-1];
	logic               blend_en = 1'b1;

	pix_cmd_t    pending_q [$];
	pix_res_t    expected_q [$];
	pix_cmd_t    cur_cmd;
	int unsigned n_queued = 0;
	int unsigned n_checked = 0;
	int unsigned n_errors = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned idle_cycles = 0;
	logic [15:0] rdy_pat = '1;
	logic [7:0]  rdy_cnt = '0;

	framebuffer_alpha_blend_pixel_port_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	initial begin
		for (int i = 0; i < NPIX; i++)
			pix_mem[i] = '1;
	end

	function automatic logic [7:0] mix_chan(input int unsigned s, input int unsigned b,
			input int unsigned a);
		int unsigned r;
		r = s * a / 255 + b - b * a / 255;
		return r[7:0];
	endfunction

	function automatic pix_res_t apply_pixel_cmd(input pix_cmd_t c);
		pix_res_t    res;
		int          sx;
		int          sy;
		int unsigned addr;
		logic [31:0] bk;
		logic [7:0]  a;
		sx = $signed(c.px);
		sy = $signed(c.py);
		res.rd_color = '0;
		res.on_scr = 1'b0;
		if (c.op == OP_FILL) begin
			for (int i = 0; i < NPIX; i++)
				pix_mem[i] = c.color;
		end else if ((c.op == OP_WRITE || c.op == OP_READ) && sx >= 0 && sx < WIDTH
				&& sy >= 0 && sy < HEIGHT) begin
			addr = sy * WIDTH + sx;
			res.on_scr = 1'b1;
			if (c.op == OP_READ) begin
				res.rd_color = pix_mem[addr];
			end else if (blend_en) begin
				bk = pix_mem[addr];
				a = c.color[31:24];
				pix_mem[addr] = {8'h00,
					mix_chan(c.color[23:16], bk[23:16], a),
					mix_chan(c.color[15:8], bk[15:8], a),
					mix_chan(c.color[7:0], bk[7:0], a)};
			end else begin
				pix_mem[addr] = c.color;
			end
		end
		return res;
	endfunction

	task automatic queue_cmd(input opcode_t op, input int x, input int y,
			input logic [31:0] color);
		pix_cmd_t c;
		c.op = op;
		c.px = x[COORD_W-1:0];
		c.py = y[COORD_W-1:0];
		c.color = color;
		pending_q.push_back(c);
		n_queued++;
	endtask

	function automatic logic [31:0] rand_color();
		logic [31:0] c;
		c = $urandom;
		case ($urandom_range(0, 5))
			0: c[31:24] = 8'h00;
			1: c[31:24] = 8'hff;
			default: ;
		endcase
		return c;
	endfunction

	task automatic queue_rand_cmd();
		opcode_t op;
		int      x;
		int      y;
		int      r;
		r = $urandom_range(0, 99);
		op = (r < 46) ? OP_WRITE : (r < 94) ? OP_READ : OP_NONE;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				x = $urandom_range(0, 7);
				y = $urandom_range(0, 3);
			end
			6: begin
				x = $urandom_range(0, 1) ? WIDTH - 1 - $urandom_range(0, 1) : 0;
				y = $urandom_range(0, 1) ? HEIGHT - 1 : 0;
			end
			7: begin
				x = $urandom_range(0, 1) ? -1 : WIDTH;
				y = $urandom_range(0, HEIGHT - 1);
				if ($urandom_range(0, 1)) begin
					x = $urandom_range(0, WIDTH - 1);
					y = $urandom_range(0, 1) ? -1 : HEIGHT;
				end
			end
			default: begin
				x = $signed(12'($urandom));
				y = $signed(12'($urandom));
			end
		endcase
		queue_cmd(op, x, y, rand_color());
	endtask

	task automatic wait_idle();
		while (n_checked != n_queued)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_alpha(input logic v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		blend_en = v;
		cfg_valid <= 1'b0;
	endtask

	// command driver, bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(apply_pixel_cmd(cur_cmd));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					cur_cmd = pending_q.pop_front();
					s_axis_tdata <= {cur_cmd.color, cur_cmd.py, cur_cmd.px};
					s_axis_tuser <= cur_cmd.op;
					s_axis_tvalid <= 1'b1;
					if (burst_left == 0)
						burst_left = $urandom_range(1, 20);
					burst_left--;
					if (burst_left == 0)
						gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				n_checked++;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected word, expected none actual %h/%b", $time,
						m_axis_tdata, m_axis_tuser);
					n_errors++;
				end else begin
					pix_res_t e;
					e = expected_q.pop_front();
					if (m_axis_tdata !== e.rd_color) begin
						$display("%0t: read_color expected %h actual %h", $time,
							e.rd_color, m_axis_tdata);
						n_errors++;
					end
					if (m_axis_tuser !== e.on_scr) begin
						$display("%0t: on_screen expected %b actual %b", $time,
							e.on_scr, m_axis_tuser);
						n_errors++;
					end
				end
			end
			rdy_cnt <= rdy_cnt + 8'd1;
			if (rdy_cnt == 8'd0)
				rdy_pat = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h1);
			else
				rdy_pat = {rdy_pat[14:0], rdy_pat[15]};
			m_axis_tready <= rdy_pat[0];
		end
	end

	// watchdog on cycles with no word moved
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int fill_at;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// store sweep after reset
		while (!s_axis_tready)
			@(posedge clk);

		write_alpha(1'b1);
		queue_cmd(OP_READ, 0, 0, 32'h0);
		queue_cmd(OP_READ, WIDTH - 1, HEIGHT - 1, 32'h0);
		queue_cmd(OP_WRITE, 0, 0, 32'h80c04080);
		queue_cmd(OP_READ, 0, 0, 32'h0);
		queue_cmd(OP_WRITE, 1, 0, 32'h00123456);
		queue_cmd(OP_WRITE, 2, 0, 32'hff123456);
		queue_cmd(OP_READ, 1, 0, 32'h0);
		queue_cmd(OP_READ, 2, 0, 32'h0);
		queue_cmd(OP_WRITE, -1, 0, 32'hffffffff);
		queue_cmd(OP_WRITE, WIDTH, 5, 32'h00000000);
		queue_cmd(OP_READ, 0, -1, 32'h0);
		queue_cmd(OP_READ, 5, HEIGHT, 32'h0);
		queue_cmd(OP_READ, -2048, -2048, 32'hffffffff);
		queue_cmd(OP_READ, 2047, 2047, 32'h0);
		queue_cmd(OP_NONE, 5, 5, 32'hdeadbeef);
		wait_idle();

		write_alpha(1'b0);
		queue_cmd(OP_WRITE, WIDTH - 1, HEIGHT - 1, 32'h12345678);
		queue_cmd(OP_READ, WIDTH - 1, HEIGHT - 1, 32'h0);
		queue_cmd(OP_FILL, 2047, -2048, 32'ha5a55a5a);
		queue_cmd(OP_READ, 0, 0, 32'h0);
		queue_cmd(OP_READ, WIDTH - 1, HEIGHT - 1, 32'h0);
		queue_cmd(OP_WRITE, 3, 3, 32'h7f00ff01);
		queue_cmd(OP_READ, 3, 3, 32'h0);
		queue_cmd(OP_NONE, -1, -1, 32'h0);
		wait_idle();

		write_alpha(1'b1);
		queue_cmd(OP_WRITE, 4, 4, 32'h7f0080ff);
		queue_cmd(OP_READ, 4, 4, 32'h0);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			write_alpha(ph % 2 == 1);
			fill_at = $urandom_range(0, 1) ? $urandom_range(0, PHASE_ITEMS - 1) : -1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == fill_at)
					queue_cmd(OP_FILL, $signed(12'($urandom)), $signed(12'($urandom)),
						$urandom_range(0, 2) == 0 ? 32'h0 : rand_color());
				queue_rand_cmd();
			end
		end
		wait_idle();

		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
